@@ sv/asl_pkg.sv @@
// asl_pkg: types, codes and helper functions of the assembler source lexer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package asl_pkg;

  localparam int NUM_KEYWORDS = 46;
  localparam logic [5:0] NO_KEYWORD = 6'd46;

  typedef enum logic [3:0] {
    K_IDENT = 4'd0, K_KEYWORD = 4'd1, K_NUMBER = 4'd2, K_LOCCNT = 4'd3,
    K_STRING = 4'd4, K_BADSTR = 4'd5, K_COMMENT = 4'd6, K_EOL = 4'd7,
    K_EOF = 4'd8, K_COLON = 4'd9, K_COMMA = 4'd10, K_PUNCT = 4'd11,
    K_UNKNOWN = 4'd12
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_BIN, M_OCT, M_HEXP, M_DEC, M_DQ, M_SQ, M_COMMENT
  } mode_t;

  localparam logic [3:0] F_BIN = 4'd1;
  localparam logic [3:0] F_OCT = 4'd2;
  localparam logic [3:0] F_DEC = 4'd4;
  localparam logic [3:0] F_HEX = 4'd8;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic       record_type;
    logic [7:0] value_char;
    logic [3:0] token_kind;
    logic [5:0] keyword_index;
    logic       last;
  } out_item_t;

  // One queue entry: up to three records caused by one input item.
  // Identifier ends are carried with a pending keyword lookup.
  typedef struct packed {
    logic [1:0] count;
    logic [2:0] is_val;     // per slot: value record
    logic [2:0] is_kw;      // per slot: ident end needing lookup
    logic [7:0] val0, val1, val2;
    logic [3:0] kind0, kind1, kind2;
  } batch_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [3:0] class_bits(input logic [7:0] c);
    logic [3:0] f;
    f = 4'd0;
    if (c == "0" || c == "1") f = f | F_BIN;
    if (c >= "0" && c <= "7") f = f | F_OCT;
    if (is_digit(c)) f = f | F_DEC;
    if (is_hex(c)) f = f | F_HEX;
    return f;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "(" ||
           c == ")" || c == "&" || c == "?" || c == "=" || c == "<" ||
           c == ">" || c == "!" || c == "." || c == 8'h5C;
  endfunction

  // Keyword text, right aligned (first char highest), zero bytes above, max 6 chars.
  function automatic logic [47:0] kw_text(input int k);
    unique case (k)
      0: return "ORG";     1: return "END";     2: return "EOT";
      3: return "SET";     4: return "EQU";     5: return "MACRO";
      6: return "ENDM";    7: return "DB";      8: return "DW";
      9: return "DS";      10: return "STACK";  11: return "MEMORY";
      12: return "IF";     13: return "ELSE";   14: return "ENDIF";
      15: return "REPT";   16: return "IRP";    17: return "IRPC";
      18: return "EXITM";  19: return "MOD";    20: return "SHR";
      21: return "SHL";    22: return "NOT";    23: return "AND";
      24: return "OR";     25: return "XOR";    26: return "EQ";
      27: return "NE";     28: return "LT";     29: return "LE";
      30: return "GT";     31: return "GE";     32: return "NUL";
      33: return "HIGH";   34: return "LOW";    35: return "ASEG";
      36: return "CSEG";   37: return "DSEG";   38: return "PUBLIC";
      39: return "EXTRN";  40: return "NAME";   41: return "STKLN";
      42: return "LOCAL";  43: return "PAGE";   44: return "INPAGE";
      default: return "CPU";
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    logic [47:0] t;
    logic [2:0]  n;
    t = kw_text(k);
    n = 3'd0;
    for (int i = 0; i < 6; i++) if (t[8*i +: 8] != 8'd0) n = n + 3'd1;
    return n;
  endfunction

endpackage

@@ sv/asl_front.sv @@
// asl_front: scanner state machine; classifies one byte per cycle while step is high into a batch.
// Depends on asl_pkg.
`timescale 1ns / 1ps
module asl_front #(
  parameter int MAX_KEYWORD_LEN = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  asl_pkg::in_item_t in_item,
  output asl_pkg::batch_t   batch,
  output logic [MAX_KEYWORD_LEN*8-1:0] ident_buf,
  output logic [$clog2(MAX_KEYWORD_LEN+1)-1:0] ident_len,
  output logic              ident_long
);
  import asl_pkg::*;
  localparam int LW = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int IW = $clog2(MAX_KEYWORD_LEN);

  mode_t      mode_r, mode_nxt;
  logic       swallow_r, swallow_nxt;
  logic [7:0] buf_r [MAX_KEYWORD_LEN];
  logic [LW-1:0] len_r, len_nxt;
  logic       long_r, long_nxt;
  logic [3:0] flags_r, flags_nxt;
  logic [7:0] lastc_r, lastc_nxt;
  logic       esc_r, esc_nxt;
  logic       dhd_r, dhd_nxt;
  logic       fin_r, fin_nxt;
  logic       buf_we;
  logic [IW-1:0] buf_wa;
  batch_t     b;
  logic [MAX_KEYWORD_LEN*8-1:0] buf_flat;

  always_comb begin
    for (int i = 0; i < MAX_KEYWORD_LEN; i++) buf_flat[8*i +: 8] = buf_r[i];
  end

  always_comb begin
    logic [7:0] c, u;
    logic eol, restart, taken;
    logic [3:0] all, need;
    mode_t m;
    c = in_item.in_char;
    u = upper(c);
    eol = (c == 8'h0D) || (c == 8'h0A);
    mode_nxt = mode_r; swallow_nxt = swallow_r; len_nxt = len_r; long_nxt = long_r;
    flags_nxt = flags_r; lastc_nxt = lastc_r; esc_nxt = esc_r; dhd_nxt = dhd_r;
    fin_nxt = fin_r; buf_we = 1'b0; buf_wa = len_r[IW-1:0];
    b = '0; restart = 1'b0; taken = 1'b0; all = '0; need = '0;
    m = mode_r;

    // Emit helpers written inline: slot index is b.count.
    if (fin_r) begin
      b.kind0 = K_EOF; b.count = 2'd1;
    end else if (in_item.end_of_input) begin
      swallow_nxt = 1'b0; fin_nxt = 1'b1; esc_nxt = 1'b0; mode_nxt = M_IDLE;
      unique case (m)
        M_IDENT: begin b.is_kw[0] = 1'b1; b.kind0 = K_IDENT; b.count = 2'd1; end
        M_BIN, M_OCT: begin b.kind0 = K_NUMBER; b.count = 2'd1; end
        M_HEXP: begin b.kind0 = dhd_r ? K_NUMBER : K_LOCCNT; b.count = 2'd1; end
        M_DEC: begin
          all = flags_r & class_bits(lastc_r);
          if (upper(lastc_r) == "B") begin all = flags_r; need = F_BIN; end
          else need = F_DEC;
          b.kind0 = ((all & need) != 0) ? K_NUMBER : K_UNKNOWN; b.count = 2'd1;
        end
        M_DQ, M_SQ: begin b.kind0 = K_BADSTR; b.count = 2'd1; end
        M_COMMENT: begin b.kind0 = K_COMMENT; b.count = 2'd1; end
        default: ;
      endcase
      if (b.count == 2'd1) b.kind1 = K_EOF; else b.kind0 = K_EOF;
      b.count = b.count + 2'd1;
    end else if (swallow_r && c == 8'h0A) begin
      swallow_nxt = 1'b0;
    end else begin
      swallow_nxt = (c == 8'h0D);
      unique case (m)
        M_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            if (len_r < LW'(MAX_KEYWORD_LEN)) begin
              buf_we = 1'b1; len_nxt = len_r + 1'b1;
            end else long_nxt = 1'b1;
            b.is_val[0] = 1'b1; b.val0 = c; b.count = 2'd1;
          end else begin
            b.is_kw[0] = 1'b1; b.kind0 = K_IDENT; b.count = 2'd1; restart = 1'b1;
          end
        end
        M_BIN, M_OCT: begin
          if (c == "0" || c == "1" || (m == M_OCT && c >= "2" && c <= "7")) begin
            b.is_val[0] = 1'b1; b.val0 = c; b.count = 2'd1;
          end else begin
            b.kind0 = K_NUMBER; b.count = 2'd1; restart = 1'b1;
          end
        end
        M_HEXP: begin
          if (is_hex(c)) begin
            dhd_nxt = 1'b1; b.is_val[0] = 1'b1; b.val0 = c; b.count = 2'd1;
          end else begin
            b.kind0 = dhd_r ? K_NUMBER : K_LOCCNT; b.count = 2'd1; restart = 1'b1;
          end
        end
        M_DEC: begin
          if (is_hex(c)) begin
            flags_nxt = flags_r & class_bits(lastc_r); lastc_nxt = c;
            b.is_val[0] = 1'b1; b.val0 = c; b.count = 2'd1;
          end else begin
            all = flags_r & class_bits(lastc_r);
            if (upper(lastc_r) == "B") begin all = flags_r; need = F_BIN; end
            else if (u == "O" || u == "Q") begin need = F_OCT; taken = 1'b1; end
            else if (u == "H") begin need = F_HEX; taken = 1'b1; end
            else need = F_DEC;
            mode_nxt = M_IDLE;
            if (taken) begin
              b.is_val[0] = 1'b1; b.val0 = c;
              b.kind1 = ((all & need) != 0) ? K_NUMBER : K_UNKNOWN; b.count = 2'd2;
            end else begin
              b.kind0 = ((all & need) != 0) ? K_NUMBER : K_UNKNOWN; b.count = 2'd1;
              restart = 1'b1;
            end
          end
        end
        M_DQ, M_SQ: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (!eol && c >= 8'h20 && c <= 8'h7E) begin
              b.is_val[0] = 1'b1; b.val0 = c; b.count = 2'd1;
            end
          end else if (eol) begin
            b.kind0 = K_BADSTR; b.count = 2'd1; restart = 1'b1;
          end else if (c == ((m == M_DQ) ? 8'h22 : 8'h27)) begin
            b.is_val[0] = 1'b1; b.val0 = c; b.kind1 = K_STRING; b.count = 2'd2;
            mode_nxt = M_IDLE;
          end else begin
            if (c == 8'h5C) esc_nxt = 1'b1;
            b.is_val[0] = 1'b1; b.val0 = c; b.count = 2'd1;
          end
        end
        M_COMMENT: begin
          if (eol) begin b.kind0 = K_COMMENT; b.count = 2'd1; restart = 1'b1; end
          else begin b.is_val[0] = 1'b1; b.val0 = c; b.count = 2'd1; end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        // Start a new token; its records follow at slot b.count.
        logic [7:0] v;
        logic       hv, he;
        kind_t      k;
        v = c; hv = 1'b0; he = 1'b0; k = K_UNKNOWN;
        mode_nxt = M_IDLE;
        if (eol) begin he = 1'b1; k = K_EOL; end
        else if (c == " " || c == 8'h09) ;
        else if (is_letter(c)) begin
          mode_nxt = M_IDENT; long_nxt = 1'b0; len_nxt = LW'(1);
          buf_we = 1'b1; buf_wa = '0; hv = 1'b1;
        end else if (is_digit(c)) begin
          mode_nxt = M_DEC; flags_nxt = 4'hF; lastc_nxt = c; hv = 1'b1;
        end else if (c == "%") begin mode_nxt = M_BIN; hv = 1'b1; end
        else if (c == "@") begin mode_nxt = M_OCT; hv = 1'b1; end
        else if (c == "$") begin mode_nxt = M_HEXP; dhd_nxt = 1'b0; hv = 1'b1; end
        else if (c == 8'h22 || c == 8'h27) begin
          mode_nxt = (c == 8'h22) ? M_DQ : M_SQ; esc_nxt = 1'b0; hv = 1'b1;
        end else if (c == ";") mode_nxt = M_COMMENT;
        else begin
          hv = 1'b1; he = 1'b1;
          k = (c == ":") ? K_COLON : (c == ",") ? K_COMMA :
              is_punct(c) ? K_PUNCT : K_UNKNOWN;
        end
        if (hv) begin
          if (b.count == 2'd0) begin b.is_val[0] = 1'b1; b.val0 = v; end
          else begin b.is_val[1] = 1'b1; b.val1 = v; end
          b.count = b.count + 2'd1;
        end
        if (he) begin
          unique case (b.count)
            2'd0: b.kind0 = k;
            2'd1: b.kind1 = k;
            default: b.kind2 = k;
          endcase
          b.count = b.count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; swallow_r <= 1'b0; len_r <= '0; long_r <= 1'b0;
      flags_r <= 4'hF; lastc_r <= 8'd0; esc_r <= 1'b0; dhd_r <= 1'b0; fin_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt; swallow_r <= swallow_nxt; len_r <= len_nxt;
      long_r <= long_nxt; flags_r <= flags_nxt; lastc_r <= lastc_nxt;
      esc_r <= esc_nxt; dhd_r <= dhd_nxt; fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && buf_we) buf_r[buf_wa] <= in_item.in_char;
  end

  assign batch      = b;
  assign ident_buf  = buf_flat;
  assign ident_len  = len_r;
  assign ident_long = long_r;
endmodule

@@ sv/asl_back.sv @@
// asl_back: two-entry batch queue and serializer emitting one record per cycle while out_stall is low.
// Depends on asl_pkg.
`timescale 1ns / 1ps
module asl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  asl_pkg::batch_t    push_batch,
  input  logic [5:0]         push_kw,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output asl_pkg::out_item_t out_item
);
  import asl_pkg::*;

  batch_t     q_r [2];
  logic [5:0] kw_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [1:0] slot_r;
  batch_t     h;
  logic       pop, done;
  logic [7:0] v;
  logic [3:0] k;
  logic       isv, iskw;

  assign h = q_r[rp_r];
  assign full = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);

  always_comb begin
    unique case (slot_r)
      2'd0: begin v = h.val0; k = h.kind0; isv = h.is_val[0]; iskw = h.is_kw[0]; end
      2'd1: begin v = h.val1; k = h.kind1; isv = h.is_val[1]; iskw = h.is_kw[1]; end
      default: begin v = h.val2; k = h.kind2; isv = h.is_val[2]; iskw = h.is_kw[2]; end
    endcase
    done = (slot_r + 2'd1 == h.count);
    out_item.record_type = !isv;
    out_item.value_char = isv ? v : 8'd0;
    out_item.token_kind = isv ? 4'd0 : (iskw && kw_r[rp_r] != NO_KEYWORD) ? K_KEYWORD : k;
    out_item.keyword_index = (iskw && !isv) ? kw_r[rp_r] : NO_KEYWORD;
    out_item.last = done;
  end

  assign pop = out_valid && !out_stall && done;

  always_ff @(posedge clk) begin
    if (push) begin q_r[wp_r] <= push_batch; kw_r[wp_r] <= push_kw; end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0; slot_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (out_valid && !out_stall) begin
        if (done) begin slot_r <= 2'd0; rp_r <= !rp_r; end
        else slot_r <= slot_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ sv/assembler_source_lexer.sv @@
// assembler_source_lexer: top level; front scanner, keyword match, back queue.
// Depends on asl_pkg, asl_front, asl_back.
`timescale 1ns / 1ps
// Usage:
//   in_ channel: one source byte per item (in_char), or end_of_input set.
//   out_ channel: result records, one per cycle while out_stall is low;
//   "last" marks the final record caused by an item. Items causing no record
//   (blanks, a swallowed LF after CR, escaped control bytes) give nothing.
// An accepted item's batch is registered in the queue before its records are sent.
// The front scans one item per cycle unless in_stall is high; the back sends one
//   record per cycle unless out_stall is high. An item gives 0..3 records, and the
//   serializer sends each of them; an item that gives none is not queued.
// A two-entry batch queue parts front and back; in_stall rises only when
//   both entries hold batches, so the front keeps taking items while a
//   result waits on a stalled receiver.
// Reset (rst_n low, synchronous): scanner idle between tokens, queue empty.
// While out_stall is high the current record holds steady.
// Keyword lookup is done in the front cycle against the constant table.
module assembler_source_lexer #(
  parameter int MAX_KEYWORD_LEN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  asl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output asl_pkg::out_item_t out_data
);
  import asl_pkg::*;
  localparam int LW = $clog2(MAX_KEYWORD_LEN + 1);

  logic   step, full;
  batch_t batch;
  logic [MAX_KEYWORD_LEN*8-1:0] ibuf;
  logic [LW-1:0] ilen;
  logic   ilong;
  logic [5:0] kw;

  assign in_stall = full;
  assign step = in_valid && !full;

  asl_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_front (
    .clk, .rst_n, .step, .in_item(in_data), .batch,
    .ident_buf(ibuf), .ident_len(ilen), .ident_long(ilong)
  );

  // Keyword match on the stored identifier (independent compares).
  always_comb begin
    logic        same;
    logic [47:0] t;
    int          n;
    kw = NO_KEYWORD;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      t = kw_text(k);
      n = int'(kw_len(k));
      same = !ilong && (ilen == LW'(n));
      for (int i = 0; i < 6; i++)
        if (i < n && i < MAX_KEYWORD_LEN)
          if (ibuf[8*i +: 8] != t[8*(n-1-i) +: 8]) same = 1'b0;
      if (same) kw = 6'(k);
    end
  end

  asl_back u_back (
    .clk, .rst_n, .push(step && batch.count != 2'd0), .push_batch(batch),
    .push_kw(kw), .full, .out_valid, .out_stall, .out_item(out_data)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !step) else $error("push into full queue");
  a_eof_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.record_type && out_data.token_kind == K_EOF)
      |-> out_data.last) else $error("eof not last");
  a_val_kw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.record_type) |-> out_data.keyword_index == NO_KEYWORD)
    else $error("value record with keyword");
endmodule
